// File: rtl/tebe_pkg.sv
package tebe_pkg;

  // Sizing of the block store and of the per-event staging buffer.
  localparam int BLOCK_BYTES_DEF = 64;
  localparam int MIN_BLOCK       = 24;
  localparam int STAGE_DEPTH     = 32;
  localparam int STAGE_AW        = 5;

  // At most this many beats leave for one input item.
  localparam int MAX_RESULTS     = 24;
  localparam int RCW             = 5;

  // The header is eight words.
  localparam int HDR_WORDS       = 8;
  localparam int HDR_AW          = 3;

  // Reflected CRC-32.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Register reset values.
  localparam logic [31:0] EVENT_CODES_RST = 32'h0302_0100;
  localparam logic [6:0]  CAPACITY_RST    = 7'd64;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RECORD_FLAGS   = 3'd0;
  localparam logic [2:0] CFG_BUILD_ID       = 3'd1;
  localparam logic [2:0] CFG_REPLAY_SEED    = 3'd2;
  localparam logic [2:0] CFG_TRACE_MAGIC    = 3'd3;
  localparam logic [2:0] CFG_FORMAT_VERSION = 3'd4;
  localparam logic [2:0] CFG_EVENT_CODES    = 3'd5;
  localparam logic [2:0] CFG_BLOCK_CAPACITY = 3'd6;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_IRQ    = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_IRQ   = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FLD_DELTA = 2'd0,
    FLD_ADDR  = 2'd1,
    FLD_VALUE = 2'd2
  } fld_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HDR,
    ST_VARINT,
    ST_FIT,
    ST_COPY,
    ST_FL_LEN,
    ST_FL_RD,
    ST_FL_ACC,
    ST_FL_CRC,
    ST_ZERO,
    ST_FINAL
  } state_t;

  // Outcome of decoding one item against the current flags.
  typedef struct packed {
    logic go_hdr;
    logic go_build;
    logic set_failed;
    logic set_finished;
    logic ok;
  } dec_t;

  // One byte through the reflected CRC-32, a bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: rtl/trace_event_block_encoder_top.sv
// Trace event block encoder. One event is taken at a time; in_stall stays high
// until its last beat has been handed to the output register. A begin gives
// eight header beats. A read, write, interrupt or finish event is first built
// byte by byte in a staging buffer by one shared 7-bit shift unit (up to 20
// varint bytes after the type byte), then copied into the block store at one
// byte a cycle. When the block is flushed, the store is walked byte by byte
// through its single read port, feeding the CRC and the word packer; a finish
// also gives a terminating zero word. A stalled output holds each of these
// steps until its beat can move. The output register lets the last beat wait
// under out_stall while the next event is accepted.
module trace_event_block_encoder_top #(
  parameter int BLOCK_BYTES = tebe_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_timestamp,
  input  logic [31:0] in_address,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word,
  output logic [2:0]  out_byte_count,
  output logic        out_run_last,
  output logic        out_status_ok
);

  localparam int FW   = $clog2(BLOCK_BYTES + 1);
  localparam int AW   = $clog2(BLOCK_BYTES);
  localparam int CMPW = FW + 2;

  // Configuration registers.
  logic [15:0] rec_flags_r;
  logic [63:0] build_id_r;
  logic [63:0] seed_r;
  logic [31:0] magic_r;
  logic [15:0] version_r;
  logic [31:0] codes_r;
  logic [6:0]  capacity_r;

  // Sequencer and item.
  tebe_pkg::state_t state_r, state_nxt;
  logic [2:0]  op_r;
  logic [63:0] ts_r;
  logic [31:0] addr_r;
  logic [31:0] val_r;

  // Encoder state.
  logic [63:0] prev_time_r, prev_time_nxt;
  logic [31:0] prev_addr_r, prev_addr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic started_r, started_nxt;
  logic finished_r, finished_nxt;
  logic failed_r, failed_nxt;
  logic ok_r, ok_nxt;

  // Varint builder and copy counters.
  tebe_pkg::kind_t kind_r, kind_nxt;
  tebe_pkg::fld_t  fld_r, fld_nxt;
  logic [63:0] vbuf_r, vbuf_nxt;
  logic [33:0] zz_r, zz_nxt;
  logic [tebe_pkg::STAGE_AW-1:0] sidx_r, sidx_nxt;
  logic [tebe_pkg::STAGE_AW-1:0] cidx_r, cidx_nxt;
  logic [tebe_pkg::HDR_AW-1:0]   hidx_r, hidx_nxt;

  // Flush walker.
  logic [FW-1:0] bidx_r, bidx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] wacc_r, wacc_nxt;
  logic [7:0]  rdata_r;
  logic        ret_zero_r, ret_zero_nxt;

  // Result holding.
  logic [tebe_pkg::RCW-1:0] rcount_r, rcount_nxt;
  logic        pend_vld_r;
  logic [31:0] pend_word_r;
  logic [2:0]  pend_cnt_r;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_cnt_r;
  logic        out_last_r;
  logic        out_ok_r;

  // Memories.
  logic [7:0] stage_mem [tebe_pkg::STAGE_DEPTH];
  logic [7:0] store_mem [BLOCK_BYTES];

  logic        in_acc;
  tebe_pkg::dec_t dec;
  logic        backward;
  logic [63:0] delta;
  logic [32:0] diff33;
  logic [33:0] zz_calc;
  logic [1:0]  kind_dec;
  logic [7:0]  code_byte;
  logic        vmore;
  logic [7:0]  vbyte;
  logic        vdone;
  logic [CMPW-1:0] cap_raw;
  logic [CMPW-1:0] cap_eff;
  logic        need_flush;
  logic [7:0]  stage_rd;
  logic [FW:0] st_waddr;
  logic        copy_last;
  logic [1:0]  pos;
  logic        acc_last;
  logic [31:0] acc_word;
  logic [31:0] hdr_word;
  logic        stage_we;
  logic [tebe_pkg::STAGE_AW-1:0] stage_waddr;
  logic [7:0]  stage_wdata;
  logic        store_we;
  logic        prod;
  logic [31:0] prod_word;
  logic [2:0]  prod_cnt;
  logic        drop;
  logic        can_push;
  logic        adv;
  logic        mid_push;
  logic        fin_push;
  logic        load_pend;

  assign in_stall       = (state_r != tebe_pkg::ST_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_byte_count = out_cnt_r;
  assign out_run_last   = out_last_r;
  assign out_status_ok  = out_ok_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_flags_r <= '0;
      build_id_r  <= '0;
      seed_r      <= '0;
      magic_r     <= '0;
      version_r   <= '0;
      codes_r     <= tebe_pkg::EVENT_CODES_RST;
      capacity_r  <= tebe_pkg::CAPACITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tebe_pkg::CFG_RECORD_FLAGS:   rec_flags_r <= cfg_data[15:0];
        tebe_pkg::CFG_BUILD_ID:       build_id_r  <= cfg_data;
        tebe_pkg::CFG_REPLAY_SEED:    seed_r      <= cfg_data;
        tebe_pkg::CFG_TRACE_MAGIC:    magic_r     <= cfg_data[31:0];
        tebe_pkg::CFG_FORMAT_VERSION: version_r   <= cfg_data[15:0];
        tebe_pkg::CFG_EVENT_CODES:    codes_r     <= cfg_data[31:0];
        tebe_pkg::CFG_BLOCK_CAPACITY: capacity_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Wide arithmetic done once in decode: timestamp delta and zigzag address delta.
  assign backward = (ts_r < prev_time_r);
  assign delta    = ts_r - prev_time_r;
  assign diff33   = {1'b0, addr_r} - {1'b0, prev_addr_r};
  assign zz_calc  = diff33[32] ? ~{diff33, 1'b0} : {diff33, 1'b0};
  assign kind_dec = 2'(op_r - 3'd1);
  assign code_byte = 8'(codes_r >> {kind_dec, 3'b000});

  // Item decode against the sticky flags.
  always_comb begin
    dec = '0;
    case (op_r)
      tebe_pkg::OP_BEGIN: begin
        if (started_r || (capacity_r < 7'(tebe_pkg::MIN_BLOCK))) begin
          dec.set_failed = 1'b1;
        end else begin
          dec.go_hdr = 1'b1;
          dec.ok     = 1'b1;
        end
      end
      tebe_pkg::OP_READ, tebe_pkg::OP_WRITE, tebe_pkg::OP_IRQ: begin
        if ((op_r == tebe_pkg::OP_WRITE) && !rec_flags_r[0]) begin
          dec.ok = started_r && !failed_r;
        end else if (failed_r || !started_r || finished_r) begin
          dec.ok = 1'b0;
        end else if (backward) begin
          dec.set_failed = 1'b1;
        end else begin
          dec.go_build = 1'b1;
          dec.ok       = 1'b1;
        end
      end
      tebe_pkg::OP_FINISH: begin
        if (!started_r || finished_r) begin
          dec.ok = 1'b0;
        end else if (failed_r) begin
          dec.set_finished = 1'b1;
        end else if (backward) begin
          dec.set_failed   = 1'b1;
          dec.set_finished = 1'b1;
        end else begin
          dec.go_build = 1'b1;
          dec.ok       = 1'b1;
        end
      end
      default: dec = '0;
    endcase
  end

  // Shared varint unit: seven bits leave per cycle.
  assign vmore = |vbuf_r[63:7];
  assign vbyte = {vmore, vbuf_r[6:0]};
  assign vdone = !vmore && ((fld_r == tebe_pkg::FLD_VALUE) ||
                 ((fld_r == tebe_pkg::FLD_DELTA) && (kind_r == tebe_pkg::KIND_STOP)));

  // Capacity is clamped to the legal range and read live.
  assign cap_raw = CMPW'(capacity_r);
  assign cap_eff = (cap_raw > CMPW'(BLOCK_BYTES)) ? CMPW'(BLOCK_BYTES) :
                   (cap_raw < CMPW'(tebe_pkg::MIN_BLOCK)) ? CMPW'(tebe_pkg::MIN_BLOCK) :
                   cap_raw;
  assign need_flush = ((CMPW'(fill_r) + CMPW'(sidx_r)) > cap_eff) && (fill_r != '0);

  // Copy from staging into the store.
  assign stage_rd  = stage_mem[cidx_r];
  assign st_waddr  = (FW+1)'(fill_r) + (FW+1)'(cidx_r);
  assign copy_last = (cidx_r == (sidx_r - 1'b1));

  // Word packing of store bytes during a flush.
  assign pos      = bidx_r[1:0];
  assign acc_last = (((FW+1)'(bidx_r) + 1'b1) == (FW+1)'(fill_r));
  assign acc_word = (pos == 2'd0) ? {24'h0, rdata_r} :
                    (wacc_r | ({24'h0, rdata_r} << {pos, 3'b000}));

  // Header words, little-endian.
  always_comb begin
    case (hidx_r)
      3'd0:    hdr_word = magic_r;
      3'd1:    hdr_word = {rec_flags_r, version_r};
      3'd2:    hdr_word = build_id_r[31:0];
      3'd3:    hdr_word = build_id_r[63:32];
      3'd4:    hdr_word = seed_r[31:0];
      3'd5:    hdr_word = seed_r[63:32];
      default: hdr_word = '0;
    endcase
  end

  // Beat production and the pending/output hand-off.
  always_comb begin
    prod      = 1'b0;
    prod_word = '0;
    prod_cnt  = 3'd4;
    case (state_r)
      tebe_pkg::ST_HDR: begin
        prod      = 1'b1;
        prod_word = hdr_word;
      end
      tebe_pkg::ST_FL_LEN: begin
        prod      = 1'b1;
        prod_word = 32'(fill_r);
      end
      tebe_pkg::ST_FL_ACC: begin
        prod      = (pos == 2'd3) || acc_last;
        prod_word = acc_word;
        prod_cnt  = {1'b0, pos} + 3'd1;
      end
      tebe_pkg::ST_FL_CRC: begin
        prod      = 1'b1;
        prod_word = ~crc_r;
      end
      tebe_pkg::ST_ZERO: begin
        prod      = 1'b1;
        prod_word = '0;
      end
      default: prod = 1'b0;
    endcase
  end

  assign can_push  = !out_valid_r || !out_stall;
  assign drop      = (rcount_r == tebe_pkg::RCW'(tebe_pkg::MAX_RESULTS));
  assign adv       = !prod || drop || !pend_vld_r || can_push;
  assign mid_push  = prod && !drop && pend_vld_r && can_push;
  assign fin_push  = (state_r == tebe_pkg::ST_FINAL) && can_push;
  assign load_pend = prod && !drop && adv;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tebe_pkg::ST_IDLE:   if (in_acc) state_nxt = tebe_pkg::ST_DECODE;
      tebe_pkg::ST_DECODE: begin
        if (dec.go_hdr) begin
          state_nxt = tebe_pkg::ST_HDR;
        end else if (dec.go_build) begin
          state_nxt = tebe_pkg::ST_VARINT;
        end else begin
          state_nxt = tebe_pkg::ST_FINAL;
        end
      end
      tebe_pkg::ST_HDR: begin
        if (adv && (hidx_r == tebe_pkg::HDR_AW'(tebe_pkg::HDR_WORDS - 1))) begin
          state_nxt = tebe_pkg::ST_FINAL;
        end
      end
      tebe_pkg::ST_VARINT: if (vdone) state_nxt = tebe_pkg::ST_FIT;
      tebe_pkg::ST_FIT: begin
        state_nxt = need_flush ? tebe_pkg::ST_FL_LEN : tebe_pkg::ST_COPY;
      end
      tebe_pkg::ST_COPY: begin
        if (copy_last) begin
          state_nxt = (kind_r == tebe_pkg::KIND_STOP) ? tebe_pkg::ST_FL_LEN :
                      tebe_pkg::ST_FINAL;
        end
      end
      tebe_pkg::ST_FL_LEN: if (adv) state_nxt = tebe_pkg::ST_FL_RD;
      tebe_pkg::ST_FL_RD:  state_nxt = tebe_pkg::ST_FL_ACC;
      tebe_pkg::ST_FL_ACC: begin
        if (adv) begin
          state_nxt = acc_last ? tebe_pkg::ST_FL_CRC : tebe_pkg::ST_FL_RD;
        end
      end
      tebe_pkg::ST_FL_CRC: begin
        if (adv) begin
          state_nxt = ret_zero_r ? tebe_pkg::ST_ZERO : tebe_pkg::ST_COPY;
        end
      end
      tebe_pkg::ST_ZERO:  if (adv) state_nxt = tebe_pkg::ST_FINAL;
      tebe_pkg::ST_FINAL: if (can_push) state_nxt = tebe_pkg::ST_IDLE;
      default: state_nxt = tebe_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    prev_time_nxt = prev_time_r;
    prev_addr_nxt = prev_addr_r;
    fill_nxt      = fill_r;
    started_nxt   = started_r;
    finished_nxt  = finished_r;
    failed_nxt    = failed_r;
    ok_nxt        = ok_r;
    kind_nxt      = kind_r;
    fld_nxt       = fld_r;
    vbuf_nxt      = vbuf_r;
    zz_nxt        = zz_r;
    sidx_nxt      = sidx_r;
    cidx_nxt      = cidx_r;
    hidx_nxt      = hidx_r;
    bidx_nxt      = bidx_r;
    crc_nxt       = crc_r;
    wacc_nxt      = wacc_r;
    ret_zero_nxt  = ret_zero_r;
    rcount_nxt    = rcount_r;
    stage_we      = 1'b0;
    stage_waddr   = sidx_r;
    stage_wdata   = vbyte;
    store_we      = 1'b0;

    if (in_acc) rcount_nxt = '0;
    if (load_pend) rcount_nxt = rcount_r + 1'b1;

    case (state_r)
      tebe_pkg::ST_DECODE: begin
        ok_nxt = dec.ok;
        if (dec.set_failed) failed_nxt = 1'b1;
        if (dec.set_finished) finished_nxt = 1'b1;
        if (dec.go_hdr) begin
          fill_nxt      = '0;
          prev_time_nxt = '0;
          prev_addr_nxt = '0;
          failed_nxt    = 1'b0;
          started_nxt   = 1'b1;
          hidx_nxt      = '0;
        end
        if (dec.go_build) begin
          kind_nxt    = tebe_pkg::kind_t'(kind_dec);
          fld_nxt     = tebe_pkg::FLD_DELTA;
          vbuf_nxt    = delta;
          zz_nxt      = zz_calc;
          sidx_nxt    = tebe_pkg::STAGE_AW'(1);
          stage_we    = 1'b1;
          stage_waddr = '0;
          stage_wdata = code_byte;
        end
      end
      tebe_pkg::ST_HDR: begin
        if (adv) hidx_nxt = hidx_r + 1'b1;
      end
      tebe_pkg::ST_VARINT: begin
        stage_we = 1'b1;
        sidx_nxt = sidx_r + 1'b1;
        vbuf_nxt = vbuf_r >> 7;
        if (!vmore) begin
          case (fld_r)
            tebe_pkg::FLD_DELTA: begin
              if (kind_r == tebe_pkg::KIND_READ || kind_r == tebe_pkg::KIND_WRITE) begin
                fld_nxt  = tebe_pkg::FLD_ADDR;
                vbuf_nxt = 64'(zz_r);
              end else if (kind_r == tebe_pkg::KIND_IRQ) begin
                fld_nxt  = tebe_pkg::FLD_VALUE;
                vbuf_nxt = 64'(val_r);
              end
            end
            tebe_pkg::FLD_ADDR: begin
              fld_nxt  = tebe_pkg::FLD_VALUE;
              vbuf_nxt = 64'(val_r);
            end
            default: fld_nxt = fld_r;
          endcase
        end
      end
      tebe_pkg::ST_FIT: begin
        cidx_nxt     = '0;
        ret_zero_nxt = 1'b0;
      end
      tebe_pkg::ST_COPY: begin
        store_we = 1'b1;
        cidx_nxt = cidx_r + 1'b1;
        if (copy_last) begin
          fill_nxt      = fill_r + FW'(sidx_r);
          prev_time_nxt = ts_r;
          if (kind_r == tebe_pkg::KIND_READ || kind_r == tebe_pkg::KIND_WRITE) begin
            prev_addr_nxt = addr_r;
          end
          ret_zero_nxt = 1'b1;
        end
      end
      tebe_pkg::ST_FL_LEN: begin
        crc_nxt  = tebe_pkg::CRC_INIT;
        bidx_nxt = '0;
        wacc_nxt = '0;
      end
      tebe_pkg::ST_FL_ACC: begin
        if (adv) begin
          crc_nxt  = tebe_pkg::crc_byte(crc_r, rdata_r);
          wacc_nxt = acc_word;
          bidx_nxt = bidx_r + 1'b1;
        end
      end
      tebe_pkg::ST_FL_CRC: begin
        if (adv) fill_nxt = '0;
      end
      tebe_pkg::ST_ZERO: begin
        if (adv) finished_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tebe_pkg::ST_IDLE;
      prev_time_r <= '0;
      prev_addr_r <= '0;
      fill_r      <= '0;
      started_r   <= 1'b0;
      finished_r  <= 1'b0;
      failed_r    <= 1'b0;
      rcount_r    <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_time_r <= prev_time_nxt;
      prev_addr_r <= prev_addr_nxt;
      fill_r      <= fill_nxt;
      started_r   <= started_nxt;
      finished_r  <= finished_nxt;
      failed_r    <= failed_nxt;
      rcount_r    <= rcount_nxt;
      if (fin_push) begin
        pend_vld_r <= 1'b0;
      end else if (load_pend) begin
        pend_vld_r <= 1'b1;
      end
      if (mid_push || fin_push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_opcode;
      ts_r   <= in_timestamp;
      addr_r <= in_address;
      val_r  <= in_payload;
    end
    ok_r       <= ok_nxt;
    kind_r     <= kind_nxt;
    fld_r      <= fld_nxt;
    vbuf_r     <= vbuf_nxt;
    zz_r       <= zz_nxt;
    sidx_r     <= sidx_nxt;
    cidx_r     <= cidx_nxt;
    hidx_r     <= hidx_nxt;
    bidx_r     <= bidx_nxt;
    crc_r      <= crc_nxt;
    wacc_r     <= wacc_nxt;
    ret_zero_r <= ret_zero_nxt;
    if (load_pend) begin
      pend_word_r <= prod_word;
      pend_cnt_r  <= prod_cnt;
    end
    if (mid_push || fin_push) begin
      out_word_r <= pend_vld_r ? pend_word_r : '0;
      out_cnt_r  <= pend_vld_r ? pend_cnt_r : 3'd0;
      out_last_r <= fin_push;
      out_ok_r   <= ok_r;
    end
  end

  // Staging buffer for the bytes of one event.
  always_ff @(posedge clk) begin
    if (stage_we) stage_mem[stage_waddr] <= stage_wdata;
  end

  // Block store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store_we) store_mem[st_waddr[AW-1:0]] <= stage_rd;
    if (state_r == tebe_pkg::ST_FL_RD) rdata_r <= store_mem[bidx_r[AW-1:0]];
  end

endmodule

// File: tb/tb.sv
module tb;

  localparam int HALF_PERIOD = 4;
  localparam int WATCH_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_ITEMS = 50;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [63:0] TS_TOP = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic [63:0] in_timestamp;
  logic [31:0] in_address;
  logic [31:0] in_payload;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_word;
  logic [2:0]  out_byte_count;
  logic        out_run_last;
  logic        out_status_ok;

  trace_event_block_encoder_top i_dut (.*);

  // One beat of the output stream as the encoder should present it.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        last;
    logic        ok;
  } beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
  } chunk_t;

  // A directed event; status-only rows may carry their status typed in.
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] ts;
    logic [31:0] addr;
    logic [31:0] val;
    bit          typed;
    bit          t_ok;
  } row_t;

  beat_t  pending_beats[$];
  chunk_t stream_chunks[$];
  byte unsigned ev_bytes[$];
  row_t   plan[$];

  // Shadow of the registers and of the encoder state.
  logic [15:0] rec_flags;
  logic [63:0] build_val, seed_val;
  logic [31:0] magic_val, codes_val;
  logic [15:0] version_val;
  logic [6:0]  cap_val;
  logic [63:0] last_ts;
  logic [31:0] last_addr;
  byte unsigned blk[tebe_pkg::BLOCK_BYTES_DEF];
  int          fill;
  bit          started, finished, failed;

  int  fail_cnt;
  bit  in_idle_on, out_idle_on;
  int  quiet_cycles;
  logic [63:0] ts_cur;
  logic [31:0] addr_cur;

  always #HALF_PERIOD clk = ~clk;

  function automatic void push_bytes(byte unsigned b[$]);
    int i;
    int k;
    logic [31:0] w;
    i = 0;
    while (i < b.size()) begin
      w = '0;
      k = 0;
      while (k < 4 && i < b.size()) begin
        w[8*k +: 8] = b[i];
        k++;
        i++;
      end
      if (stream_chunks.size() < tebe_pkg::MAX_RESULTS) stream_chunks.push_back('{w, 3'(k)});
    end
  endfunction

  function automatic void push_word(logic [31:0] v);
    byte unsigned b[$];
    for (int i = 0; i < 4; i++) b.push_back(v[8*i +: 8]);
    push_bytes(b);
  endfunction

  function automatic logic [31:0] block_crc(int n);
    logic [31:0] c;
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      c ^= {24'h0, blk[i]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return ~c;
  endfunction

  // A block leaves as length word, data bytes and CRC word.
  function automatic void drain_block();
    byte unsigned b[$];
    if (fill == 0) return;
    push_word(32'(fill));
    for (int i = 0; i < fill; i++) b.push_back(blk[i]);
    push_bytes(b);
    push_word(block_crc(fill));
    fill = 0;
  endfunction

  function automatic void add_varint(logic [63:0] v);
    while (v >= 64'h80) begin
      ev_bytes.push_back({1'b1, v[6:0]});
      v >>= 7;
    end
    ev_bytes.push_back(v[7:0]);
  endfunction

  function automatic bit encode_event(tebe_pkg::kind_t kind, logic [63:0] ts,
                                      logic [31:0] addr, logic [31:0] val);
    int lim;
    logic [63:0] d;
    if (failed || !started || finished) return 0;
    if (ts < last_ts) begin
      failed = 1;
      return 0;
    end
    ev_bytes.delete();
    ev_bytes.push_back(codes_val[8*kind +: 8]);
    add_varint(ts - last_ts);
    if (kind == tebe_pkg::KIND_READ || kind == tebe_pkg::KIND_WRITE) begin
      d = {32'h0, addr} - {32'h0, last_addr};
      add_varint((d << 1) ^ {64{d[63]}});
    end
    if (kind != tebe_pkg::KIND_STOP) add_varint({32'h0, val});
    // The capacity register is clamped between the minimum block and what the store can hold.
    lim = cap_val;
    if (lim > tebe_pkg::BLOCK_BYTES_DEF) lim = tebe_pkg::BLOCK_BYTES_DEF;
    if (lim < tebe_pkg::MIN_BLOCK) lim = tebe_pkg::MIN_BLOCK;
    if (fill + ev_bytes.size() > lim) drain_block();
    foreach (ev_bytes[i])
      if (fill + i < tebe_pkg::BLOCK_BYTES_DEF) blk[fill + i] = ev_bytes[i];
    fill += ev_bytes.size();
    last_ts = ts;
    if (kind == tebe_pkg::KIND_READ || kind == tebe_pkg::KIND_WRITE) last_addr = addr;
    return 1;
  endfunction

  function automatic bit start_trace();
    if (started || cap_val < tebe_pkg::MIN_BLOCK) begin
      failed = 1;
      return 0;
    end
    fill = 0;
    last_ts = '0;
    last_addr = '0;
    failed = 0;
    started = 1;
    ev_bytes.delete();
    for (int i = 0; i < 4; i++) ev_bytes.push_back(magic_val[8*i +: 8]);
    for (int i = 0; i < 2; i++) ev_bytes.push_back(version_val[8*i +: 8]);
    for (int i = 0; i < 2; i++) ev_bytes.push_back(rec_flags[8*i +: 8]);
    for (int i = 0; i < 8; i++) ev_bytes.push_back(build_val[8*i +: 8]);
    for (int i = 0; i < 8; i++) ev_bytes.push_back(seed_val[8*i +: 8]);
    for (int i = 0; i < 8; i++) ev_bytes.push_back(8'h00);
    push_bytes(ev_bytes);
    return 1;
  endfunction

  function automatic bit finish_trace(logic [63:0] ts);
    bit dummy;
    if (!started || finished) return 0;
    if (!failed) dummy = encode_event(tebe_pkg::KIND_STOP, ts, '0, '0);
    if (!failed) drain_block();
    if (!failed) push_word('0);
    finished = 1;
    return !failed;
  endfunction

  // Works out the beats one event causes and queues them for checking.
  function automatic void predict_beats(logic [2:0] op, logic [63:0] ts, logic [31:0] addr,
                                        logic [31:0] val, bit typed, bit t_ok);
    bit ok;
    stream_chunks.delete();
    case (op)
      tebe_pkg::OP_BEGIN:  ok = start_trace();
      tebe_pkg::OP_READ:   ok = encode_event(tebe_pkg::KIND_READ, ts, addr, val);
      tebe_pkg::OP_WRITE:  ok = rec_flags[0] ? encode_event(tebe_pkg::KIND_WRITE, ts, addr, val)
                                             : (started && !failed);
      tebe_pkg::OP_IRQ:    ok = encode_event(tebe_pkg::KIND_IRQ, ts, addr, val);
      tebe_pkg::OP_FINISH: ok = finish_trace(ts);
      default:             ok = 0;
    endcase
    if (failed) ok = 0;
    if (typed) begin
      stream_chunks.delete();
      ok = t_ok;
    end
    if (stream_chunks.size() == 0) stream_chunks.push_back('{32'h0, 3'd0});
    foreach (stream_chunks[i])
      pending_beats.push_back('{stream_chunks[i].word, stream_chunks[i].cnt,
                                i == stream_chunks.size() - 1, ok});
  endfunction

  // Register write, mirrored into the shadow copy.
  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    case (idx)
      tebe_pkg::CFG_RECORD_FLAGS:   rec_flags = v[15:0];
      tebe_pkg::CFG_BUILD_ID:       build_val = v;
      tebe_pkg::CFG_REPLAY_SEED:    seed_val = v;
      tebe_pkg::CFG_TRACE_MAGIC:    magic_val = v[31:0];
      tebe_pkg::CFG_FORMAT_VERSION: version_val = v[15:0];
      tebe_pkg::CFG_EVENT_CODES:    codes_val = v[31:0];
      tebe_pkg::CFG_BLOCK_CAPACITY: cap_val = v[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_beats.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  // Presents one event and waits until the encoder takes it.
  task automatic send_event(logic [2:0] op, logic [63:0] ts, logic [31:0] addr,
                            logic [31:0] val, bit typed = 0, bit t_ok = 0);
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 99) < 30) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_opcode = op;
    in_timestamp = ts;
    in_address = addr;
    in_payload = val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_beats(op, ts, addr, val, typed, t_ok);
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 3);
    write_reg(tebe_pkg::CFG_BLOCK_CAPACITY, pick == 0 ? 64'd24 : pick == 1 ? 64'd64 :
              pick == 2 ? 64'd127 : 64'($urandom_range(24, 64)));
    write_reg(tebe_pkg::CFG_RECORD_FLAGS, 64'($urandom));
    write_reg(tebe_pkg::CFG_EVENT_CODES, 64'($urandom));
    write_reg(tebe_pkg::CFG_BUILD_ID, {$urandom, $urandom});
  endtask

  // Random event with a timestamp that never moves back, by a spread of step sizes.
  task automatic random_event();
    int sel;
    logic [63:0] step;
    logic [2:0] op;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      send_event(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), {$urandom, $urandom},
                 $urandom, $urandom);
      return;
    end
    op = sel < 45 ? tebe_pkg::OP_READ : sel < 75 ? tebe_pkg::OP_WRITE : tebe_pkg::OP_IRQ;
    step = {$urandom, $urandom} & ((64'd1 << $urandom_range(0, 40)) - 1);
    ts_cur += step;
    if ($urandom_range(0, 1)) addr_cur = $urandom;
    else addr_cur = addr_cur + 32'($signed($urandom_range(0, 64)) - 32);
    send_event(op, ts_cur, addr_cur, $urandom >> $urandom_range(0, 31));
  endtask

  // Output side: random stalls and the beat-by-beat comparison.
  always @(negedge clk) out_stall <= out_idle_on && $urandom_range(0, 99) < 30;

  always @(posedge clk) begin
    beat_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $error("beat with nothing expected: word %h", out_word);
        fail_cnt++;
      end else begin
        exp_b = pending_beats.pop_front();
        if (out_word !== exp_b.word) begin
          $error("out_word: expected %h, got %h", exp_b.word, out_word);
          fail_cnt++;
        end
        if (out_byte_count !== exp_b.cnt) begin
          $error("out_byte_count: expected %0d, got %0d", exp_b.cnt, out_byte_count);
          fail_cnt++;
        end
        if (out_run_last !== exp_b.last) begin
          $error("out_run_last: expected %0d, got %0d", exp_b.last, out_run_last);
          fail_cnt++;
        end
        if (out_status_ok !== exp_b.ok) begin
          $error("out_status_ok: expected %0d, got %0d", exp_b.ok, out_status_ok);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("trace_event_block_encoder_top regression: fail");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = tebe_pkg::CFG_RECORD_FLAGS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_opcode = tebe_pkg::OP_BEGIN;
    in_timestamp = '0;
    in_address = '0;
    in_payload = '0;
    out_stall = 1'b0;
    fail_cnt = 0;
    quiet_cycles = 0;
    in_idle_on = 1;
    out_idle_on = 1;
    rec_flags = '0;
    build_val = '0;
    seed_val = '0;
    magic_val = '0;
    version_val = '0;
    codes_val = tebe_pkg::EVENT_CODES_RST;
    cap_val = tebe_pkg::CAPACITY_RST;
    last_ts = '0;
    last_addr = '0;
    fill = 0;
    started = 0;
    finished = 0;
    failed = 0;
    ts_cur = '0;
    addr_cur = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Misuse before the trace has started, and a begin with too small a block.
    write_reg(tebe_pkg::CFG_BLOCK_CAPACITY, 64'd23);
    plan.push_back('{tebe_pkg::OP_READ, 64'd0, 32'd0, 32'd0, 1, 0});
    plan.push_back('{tebe_pkg::OP_FINISH, 64'd0, 32'd0, 32'd0, 1, 0});
    plan.push_back('{OP_SPARE_LO, 64'd0, 32'd0, 32'd0, 1, 0});
    plan.push_back('{OP_SPARE_HI, 64'd0, 32'd0, 32'd0, 1, 0});
    plan.push_back('{tebe_pkg::OP_BEGIN, 64'd0, 32'd0, 32'd0, 1, 0});
    plan.push_back('{tebe_pkg::OP_IRQ, 64'd0, 32'd0, 32'd0, 1, 0});
    foreach (plan[i]) send_event(plan[i].op, plan[i].ts, plan[i].addr, plan[i].val,
                                 plan[i].typed, plan[i].t_ok);
    wait_idle();

    // Header fields at their extremes but a random seed, smallest block, writes recorded.
    write_reg(tebe_pkg::CFG_BLOCK_CAPACITY, 64'd24);
    write_reg(tebe_pkg::CFG_RECORD_FLAGS, 64'hFFFF);
    write_reg(tebe_pkg::CFG_BUILD_ID, TS_TOP);
    write_reg(tebe_pkg::CFG_REPLAY_SEED, {$urandom, $urandom});
    write_reg(tebe_pkg::CFG_TRACE_MAGIC, 64'hFFFF_FFFF);
    write_reg(tebe_pkg::CFG_FORMAT_VERSION, 64'h0000);
    write_reg(tebe_pkg::CFG_EVENT_CODES, 64'($urandom));
    plan.delete();
    plan.push_back('{tebe_pkg::OP_BEGIN, 64'd0, 32'd0, 32'd0, 0, 0});
    plan.push_back('{tebe_pkg::OP_READ, 64'd0, 32'd0, 32'd0, 0, 0});
    plan.push_back('{tebe_pkg::OP_READ, 64'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0});
    plan.push_back('{tebe_pkg::OP_READ, 64'd5, 32'd0, 32'd127, 0, 0});
    plan.push_back('{tebe_pkg::OP_WRITE, 64'd300, 32'h8000_0000, 32'd128, 0, 0});
    plan.push_back('{tebe_pkg::OP_IRQ, 64'd300, 32'h1234_5678, 32'd255, 0, 0});
    plan.push_back('{tebe_pkg::OP_WRITE, 64'h1_0000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0});
    plan.push_back('{tebe_pkg::OP_IRQ, 64'h1_0000_0080, 32'h0, 32'hFFFF_FFFF, 0, 0});
    foreach (plan[i]) send_event(plan[i].op, plan[i].ts, plan[i].addr, plan[i].val,
                                 plan[i].typed, plan[i].t_ok);
    ts_cur = 64'h1_0000_0080;
    addr_cur = 32'h7FFF_FFFF;

    // Random phases with fresh capacity, flags, codes and build ID; one phase runs flat out.
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      random_config();
      in_idle_on = (p != 2);
      out_idle_on = (p != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) random_event();
    end
    in_idle_on = 1;
    out_idle_on = 1;

    // Largest timestamp, then either a clean finish or a backward step.
    send_event(tebe_pkg::OP_READ, TS_TOP, $urandom, $urandom);
    if ($urandom_range(0, 1)) begin
      send_event(tebe_pkg::OP_FINISH, TS_TOP, 32'd0, 32'd0);
      send_event(tebe_pkg::OP_FINISH, TS_TOP, 32'd0, 32'd0, 1, 0);
      send_event(tebe_pkg::OP_READ, TS_TOP, 32'd0, 32'd0, 1, 0);
      send_event(tebe_pkg::OP_BEGIN, 64'd0, 32'd0, 32'd0, 1, 0);
    end else begin
      send_event(tebe_pkg::OP_READ, 64'd1, 32'd0, 32'd0, 1, 0);
      send_event(tebe_pkg::OP_IRQ, TS_TOP, 32'd0, 32'd3, 1, 0);
      send_event(tebe_pkg::OP_FINISH, TS_TOP, 32'd0, 32'd0, 1, 0);
      send_event(tebe_pkg::OP_FINISH, TS_TOP, 32'd0, 32'd0, 1, 0);
      send_event(tebe_pkg::OP_BEGIN, 64'd0, 32'd0, 32'd0, 1, 0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_beats.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("trace_event_block_encoder_top regression: pass");
    end else begin
      $display("trace_event_block_encoder_top regression: fail");
    end
    $finish;
  end

endmodule
